// File: sv/ntr_pkg.sv
// ntr_pkg: widths, codes, types and helpers for the top-n distinct value tracker
// no dependencies; imported by every module of the block

package ntr_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);

  localparam int CMD_W       = 1;
  localparam int VAL_W       = 64;
  localparam int CNT_W       = 32;
  localparam int RIDX_W      = 7;
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = 8;
  localparam int TOPL_W      = 8;
  localparam int CFG_IDX_W   = 2;

  // common width for small index, fill and limit compares
  localparam int WIDE_W      = (FILL_W > TOPL_W) ? FILL_W : TOPL_W;

  localparam int GROUP_SIZE  = 16;
  localparam int NGROUPS     = (MAX_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [TOPL_W-1:0] TOP_LIMIT_RESET   = TOPL_W'(100);
  localparam logic [VAL_W-1:0]  VALUE_LIMIT_RESET = {1'b0, {(VAL_W-1){1'b1}}};

  localparam logic [CMD_W-1:0] CMD_OFFER = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TOP_LIMIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW  = 3'd0,
    ST_BUMP = 3'd1,
    ST_DROP = 3'd2,
    ST_OVER = 3'd3,
    ST_READ = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic bump;
    logic grab;
  } cell_ctrl_t;

  typedef struct packed {
    logic any_eq;
    logic any_le;
  } row_flags_t;

  // top_limit clamped to 1..MAX_ENTRIES
  function automatic logic [FILL_W-1:0] eff_limit(input logic [TOPL_W-1:0] tl);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(tl);
    if (w == '0) begin
      w = WIDE_W'(1);
    end else if (w > WIDE_W'(MAX_ENTRIES)) begin
      w = WIDE_W'(MAX_ENTRIES);
    end
    return FILL_W'(w);
  endfunction

endpackage

// File: sv/ntr_in_if.sv
// ntr_in_if: request channel (command, sample, read index) with valid/ready
// depends on ntr_pkg

interface ntr_in_if import ntr_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] sample;
  logic [RIDX_W-1:0]       read_index;

  modport source (output valid, command, sample, read_index, input ready);
  modport sink   (input valid, command, sample, read_index, output ready);
endinterface

// File: sv/ntr_out_if.sv
// ntr_out_if: result channel (status, occupancy, entry fields) with valid/ready
// depends on ntr_pkg

interface ntr_out_if import ntr_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [OCC_W-1:0]        occupancy;
  logic                    entry_valid;
  logic signed [VAL_W-1:0] entry_value;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, occupancy, entry_valid, entry_value, entry_count,
                  input ready);
  modport sink   (input valid, status, occupancy, entry_valid, entry_value, entry_count,
                  output ready);
endinterface

// File: sv/ntr_cfg_if.sv
// ntr_cfg_if: configuration write channel (register index, data) with valid/ready
// depends on ntr_pkg

interface ntr_cfg_if import ntr_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/ntr_cell.sv
// ntr_cell: one list slot holding a value and its count, with compare flags
// and shift-in from the neighbour above; depends on ntr_pkg

module ntr_cell import ntr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctrl_t              ctrl,
  input  logic [WIDE_W-1:0]       my_index,
  input  logic [FILL_W-1:0]       fill,
  input  logic signed [VAL_W-1:0] sample,
  input  logic [RIDX_W-1:0]       read_idx,
  input  logic [VAL_W-1:0]        prev_value,
  input  logic [CNT_W-1:0]        prev_count,
  input  logic                    prev_gt,
  output logic [VAL_W-1:0]        value,
  output logic [CNT_W-1:0]        count,
  output logic                    gt,
  output logic                    eq,
  output logic                    le,
  output logic [VAL_W-1:0]        rd_value,
  output logic [CNT_W-1:0]        rd_count
);

  logic in_list;
  logic vld;
  logic sel;

  assign in_list = my_index < WIDE_W'(fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      gt  <= 1'b0;
      eq  <= 1'b0;
      vld <= 1'b0;
      sel <= 1'b0;
    end else if (ctrl.capture) begin
      vld <= in_list;
      gt  <= in_list && ($signed(value) > sample);
      eq  <= in_list && (value == sample);
      sel <= WIDE_W'(read_idx) == my_index;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.bump && eq) begin
      if (count != '1) begin
        count <= count + 1'b1;
      end
    end else if (ctrl.insert && !gt) begin
      if (prev_gt) begin
        value <= sample;
        count <= CNT_W'(1);
      end else begin
        value <= prev_value;
        count <= prev_count;
      end
    end
  end

  assign le       = vld && !gt;
  assign rd_value = sel ? value : '0;
  assign rd_count = sel ? count : '0;

endmodule

// File: sv/ntr_row.sv
// ntr_row: the chain of list cells, flag reductions and the registered
// read-out or-tree; depends on ntr_pkg and ntr_cell

module ntr_row import ntr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cell_ctrl_t              ctrl,
  input  logic [FILL_W-1:0]       fill,
  input  logic signed [VAL_W-1:0] sample,
  input  logic [RIDX_W-1:0]       read_idx,
  output row_flags_t              flags,
  output logic [VAL_W-1:0]        rd_value,
  output logic [CNT_W-1:0]        rd_count
);

  logic [VAL_W-1:0]       vals     [MAX_ENTRIES];
  logic [CNT_W-1:0]       cnts     [MAX_ENTRIES];
  logic [VAL_W-1:0]       rvals    [MAX_ENTRIES];
  logic [CNT_W-1:0]       rcnts    [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] gt_vec;
  logic [MAX_ENTRIES-1:0] eq_vec;
  logic [MAX_ENTRIES-1:0] le_vec;

  logic [VAL_W-1:0] grp_val_or [NGROUPS];
  logic [CNT_W-1:0] grp_cnt_or [NGROUPS];
  logic [VAL_W-1:0] grp_val    [NGROUPS];
  logic [CNT_W-1:0] grp_cnt    [NGROUPS];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [VAL_W-1:0] pv;
    logic [CNT_W-1:0] pc;
    logic             pg;

    if (i == 0) begin : g_head
      assign pv = '0;
      assign pc = '0;
      assign pg = 1'b1;
    end else begin : g_body
      assign pv = vals[i-1];
      assign pc = cnts[i-1];
      assign pg = gt_vec[i-1];
    end

    ntr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .my_index   (WIDE_W'(i)),
      .fill       (fill),
      .sample     (sample),
      .read_idx   (read_idx),
      .prev_value (pv),
      .prev_count (pc),
      .prev_gt    (pg),
      .value      (vals[i]),
      .count      (cnts[i]),
      .gt         (gt_vec[i]),
      .eq         (eq_vec[i]),
      .le         (le_vec[i]),
      .rd_value   (rvals[i]),
      .rd_count   (rcnts[i])
    );
  end

  assign flags.any_eq = |eq_vec;
  assign flags.any_le = |le_vec;

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_val_or[g] = '0;
      grp_cnt_or[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < MAX_ENTRIES) begin
          grp_val_or[g] = grp_val_or[g] | rvals[g * GROUP_SIZE + k];
          grp_cnt_or[g] = grp_cnt_or[g] | rcnts[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.grab) begin
      for (int g = 0; g < NGROUPS; g++) begin
        grp_val[g] <= grp_val_or[g];
        grp_cnt[g] <= grp_cnt_or[g];
      end
    end
  end

  always_comb begin
    rd_value = '0;
    rd_count = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      rd_value = rd_value | grp_val[g];
      rd_count = rd_count | grp_cnt[g];
    end
  end

endmodule

// File: sv/top_n_distinct_value_tracker.sv
// top_n_distinct_value_tracker: sequencer, configuration registers and result
// register around the cell chain; depends on ntr_pkg, the ntr_*_if interfaces, ntr_row
//
// req carries one transaction per command: an offer of a signed 64-bit sample or
// a read of the list entry at read_index. rsp returns exactly one transaction per
// request: status, occupancy after the step and, for reads, the entry fields.
// cfg writes top_limit (index 0) and value_limit (index 1); other indexes are
// ignored. cfg is always ready; it is to be written only while the block is idle,
// and the block itself does not enforce this. Each request goes through capture,
// compare in every cell, update or read-out of the cell chain, and result load. The
// update of the whole sorted list is done in the same cycle by all cells together;
// the read-out goes through a two-level or-tree over the cells. A new request is taken
// only after the previous one has been loaded into the result register.
// The result sits in an output register: req is taken again while a result
// waits, and a stalled receiver holds the next result in the sequencer until
// the register frees. Reset empties the list, sets top_limit to 100 and
// value_limit to the largest positive value, and drops any held result.

module top_n_distinct_value_tracker import ntr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ntr_in_if.sink       req,
  ntr_out_if.source    rsp,
  ntr_cfg_if.sink      cfg
);

  state_t                  state, state_next;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] sample;
  logic [RIDX_W-1:0]       ridx;
  logic [TOPL_W-1:0]       top_limit;
  logic signed [VAL_W-1:0] value_limit;
  logic [FILL_W-1:0]       fill;
  logic                    over;
  logic                    rd_ok;
  status_t                 pend_status;

  logic                    rsp_valid;
  logic [STATUS_W-1:0]     rsp_status;
  logic [OCC_W-1:0]        rsp_occupancy;
  logic                    rsp_entry_valid;
  logic [VAL_W-1:0]        rsp_entry_value;
  logic [CNT_W-1:0]        rsp_entry_count;

  cell_ctrl_t              ctrl;
  row_flags_t              flags;
  logic [VAL_W-1:0]        rd_value;
  logic [CNT_W-1:0]        rd_count;
  logic [FILL_W-1:0]       lim;
  logic [FILL_W-1:0]       cfg_lim;
  logic                    drop;
  logic                    is_offer;
  logic                    load;
  logic                    req_fire;
  logic                    cfg_fire;

  assign lim      = eff_limit(top_limit);
  assign cfg_lim  = eff_limit(cfg.data[TOPL_W-1:0]);
  assign drop     = (fill >= lim) && !flags.any_le;
  assign is_offer = (cmd == CMD_OFFER) && !over;
  assign req_fire = req.valid && req.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign load     = (state == S_FIN) && (!rsp_valid || rsp.ready);

  ntr_row u_row (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .fill     (fill),
    .sample   (sample),
    .read_idx (ridx),
    .flags    (flags),
    .rd_value (rd_value),
    .rd_count (rd_count)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) state_next = S_CMP;
      end
      S_CMP: state_next = S_UPD;
      S_UPD: state_next = S_FIN;
      S_FIN: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready    = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.insert  = 1'b0;
    ctrl.bump    = 1'b0;
    ctrl.grab    = 1'b0;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_CMP:  ctrl.capture = 1'b1;
      S_UPD: begin
        ctrl.grab   = cmd == CMD_READ;
        ctrl.bump   = is_offer && flags.any_eq;
        ctrl.insert = is_offer && !flags.any_eq && !drop;
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd    <= req.command;
      sample <= req.sample;
      ridx   <= req.read_index;
    end
    if (state == S_CMP) begin
      over  <= sample > value_limit;
      rd_ok <= WIDE_W'(ridx) < WIDE_W'(fill);
    end
  end

  // configuration and list fill
  always_ff @(posedge clk) begin
    if (rst) begin
      top_limit   <= TOP_LIMIT_RESET;
      value_limit <= VALUE_LIMIT_RESET;
      fill        <= '0;
      pend_status <= ST_READ;
    end else begin
      if (cfg_fire) begin
        unique case (cfg.index)
          REG_TOP_LIMIT: begin
            top_limit <= cfg.data[TOPL_W-1:0];
            if (fill > cfg_lim) fill <= cfg_lim;
          end
          REG_VALUE_LIMIT: value_limit <= cfg.data;
          default: ;
        endcase
      end
      if (state == S_UPD) begin
        if (cmd == CMD_READ) begin
          pend_status <= ST_READ;
        end else if (over) begin
          pend_status <= ST_OVER;
        end else if (flags.any_eq) begin
          pend_status <= ST_BUMP;
        end else if (drop) begin
          pend_status <= ST_DROP;
        end else begin
          pend_status <= ST_NEW;
          if (fill < lim) fill <= FILL_W'(fill + 1'b1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_status      <= STATUS_W'(pend_status);
      rsp_occupancy   <= OCC_W'(fill);
      rsp_entry_valid <= (pend_status == ST_READ) && rd_ok;
      rsp_entry_value <= ((pend_status == ST_READ) && rd_ok) ? rd_value : '0;
      rsp_entry_count <= ((pend_status == ST_READ) && rd_ok) ? rd_count : '0;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.occupancy   = rsp_occupancy;
  assign rsp.entry_valid = rsp_entry_valid;
  assign rsp.entry_value = rsp_entry_value;
  assign rsp.entry_count = rsp_entry_count;
  assign cfg.ready       = 1'b1;

  a_fill_in_limit: assert property (@(posedge clk) disable iff (rst)
    fill <= lim)
    else $error("list fill above effective limit");

  a_req_starts_compare: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> state == S_CMP)
    else $error("accepted request did not start the compare cycle");

  a_insert_grows_fill: assert property (@(posedge clk) disable iff (rst)
    (ctrl.insert && (fill < lim)) |=> fill == FILL_W'($past(fill) + 1'b1))
    else $error("insert into a list with room did not grow the fill");

  a_bump_insert_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.insert && ctrl.bump))
    else $error("insert and bump in the same cycle");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the load cycle");

endmodule
